@@ hw/rtl/rcpn_pkg.sv @@
// rcpn_pkg: types and constants shared by the rc pulse capture normalizer.
// No dependencies.
package rcpn_pkg;

    typedef struct packed {
        logic [2:0]  pin_channel;
        logic        level;
        logic [31:0] time_us;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  logical_channel;
        logic [9:0]  position;
        logic [15:0] raw_width;
    } out_item_t;

    // measurement handed from front to back
    typedef struct packed {
        logic [2:0]  ch;
        logic [2:0]  lch;
        logic [15:0] width;
    } meas_t;

    localparam logic [2:0] REG_PPM_MODE    = 3'd0;
    localparam logic [2:0] REG_DEAD_BAND   = 3'd1;
    localparam logic [2:0] REG_CAL_LOW     = 3'd2;
    localparam logic [2:0] REG_CAL_HIGH    = 3'd3;
    localparam logic [2:0] REG_CHANNEL_MAP = 3'd4;

    localparam logic [11:0] CAL_LOW_RESET  = 12'd1100;
    localparam logic [11:0] CAL_HIGH_RESET = 12'd1900;
    localparam logic [17:0] MAP_RESET      = 18'd181896;
    localparam logic [11:0] LEARN_FLOOR    = 12'd800;
    localparam logic [11:0] LEARN_CEIL     = 12'd2200;
    localparam logic [10:0] NO_POSITION    = 11'd1023;

endpackage

@@ hw/rtl/rcpn_front.sv @@
// rcpn_front: edge capture, PWM/PPM timing, width measurement.
// Depends on rcpn_pkg.
module rcpn_front #(
    parameter int NUM_CHANNELS = 6,
    parameter int SYNC_GAP_US  = 4000
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  rcpn_pkg::in_item_t in_item,
    input  logic              ppm_mode,
    input  logic [17:0]       channel_map,
    output logic              m_valid,
    input  logic              m_ready,
    output rcpn_pkg::meas_t   m_item
);
    import rcpn_pkg::*;

    logic [NUM_CHANNELS-1:0][31:0] rise_reg;
    logic [31:0] train_reg;
    logic [2:0]  slot_reg;
    logic        mv_reg;
    meas_t       m_reg;

    logic        acc;
    logic [31:0] delta;
    logic [15:0] sat;
    logic [2:0]  ch;
    logic        emit;

    assign full    = mv_reg && !m_ready;
    assign acc     = push && !full;
    assign m_valid = mv_reg;
    assign m_item  = m_reg;

    always_comb
    begin
        ch    = in_item.pin_channel;
        emit  = 1'b0;
        delta = 32'd0;
        if (ppm_mode)
        begin
            ch    = slot_reg;
            delta = in_item.time_us - train_reg;
            emit  = in_item.level && (delta <= 32'(SYNC_GAP_US))
                    && (32'(slot_reg) < 32'(NUM_CHANNELS));
        end
        else if (32'(in_item.pin_channel) < 32'(NUM_CHANNELS))
        begin
            delta = in_item.time_us - rise_reg[in_item.pin_channel];
            emit  = !in_item.level;
        end
        sat = (delta > 32'd65535) ? 16'hFFFF : delta[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg  <= '0;
            train_reg <= '0;
            slot_reg  <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            if (m_ready)
                mv_reg <= 1'b0;
            if (acc)
            begin
                if (emit)
                begin
                    mv_reg      <= 1'b1;
                    m_reg.ch    <= ch;
                    m_reg.lch   <= 3'(channel_map >> (3 * ch));
                    m_reg.width <= sat;
                end
                if (ppm_mode)
                begin
                    if (in_item.level)
                    begin
                        train_reg <= in_item.time_us;
                        if (delta > 32'(SYNC_GAP_US))
                            slot_reg <= '0;
                        else if (slot_reg != 3'd7)
                            slot_reg <= slot_reg + 3'd1;
                    end
                end
                else if (in_item.level && 32'(in_item.pin_channel) < 32'(NUM_CHANNELS))
                    rise_reg[in_item.pin_channel] <= in_item.time_us;
            end
        end
    end
endmodule

@@ hw/rtl/rcpn_fifo.sv @@
// rcpn_fifo: short queue of measurements between front and back.
// Depends on rcpn_pkg.
module rcpn_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rcpn_pkg::meas_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rcpn_pkg::meas_t rd_item
);
    import rcpn_pkg::*;

    meas_t     mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_item  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                mem_reg[wp_reg] <= wr_item;
                wp_reg <= wp_reg + 2'd1;
            end
            if (rd)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr} - {2'd0, rd};
        end
    end
endmodule

@@ hw/rtl/rcpn_back.sv @@
// rcpn_back: range learning, normalization with iterative divider, result register.
// Depends on rcpn_pkg.
module rcpn_back #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             m_valid,
    output logic             m_ready,
    input  rcpn_pkg::meas_t  m_item,
    input  logic [8:0]       dead_band,
    input  logic             ld_low,
    input  logic             ld_high,
    input  logic [11:0]      cfg_val,
    output logic             empty,
    input  logic             pop,
    output rcpn_pkg::out_item_t out_item
);
    import rcpn_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DIV, S_DONE} state_t;

    state_t state_reg;
    logic [NUM_CHANNELS-1:0][11:0] lo_reg, hi_reg;
    logic [NUM_CHANNELS-1:0][10:0] last_reg;
    meas_t m_reg;
    logic [20:0] num_reg, rem_reg;
    logic [13:0] den_reg;
    logic [20:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic [9:0]  base_reg;
    logic [10:0] pfix_reg;
    logic        use_fix_reg;
    logic        ov_reg;
    out_item_t   o_reg;

    // signed working values
    logic signed [17:0] w, lo, hi, s, c, x, ilo, ihi;
    logic signed [17:0] p_fix;
    logic        fixed, upper;
    logic [11:0] nlo, nhi;
    logic [21:0] rtry;
    logic signed [23:0] pfull;
    logic [10:0] pos;
    logic [2:0]  ch_i;

    assign m_ready  = state_reg == S_IDLE && !ov_reg;
    assign empty    = !ov_reg;
    assign out_item = o_reg;
    assign ch_i     = m_reg.ch;

    always_comb
    begin
        nlo = lo_reg[ch_i];
        nhi = hi_reg[ch_i];
        if ({4'd0, m_reg.width} < {4'd0, nlo} && m_reg.width > {4'd0, LEARN_FLOOR})
            nlo = m_reg.width[11:0];
        if ({4'd0, m_reg.width} > {4'd0, nhi} && m_reg.width < {4'd0, LEARN_CEIL})
            nhi = m_reg.width[11:0];
        w  = $signed({2'b0, m_reg.width});
        lo = $signed({6'b0, nlo});
        hi = $signed({6'b0, nhi});
        s  = $signed({9'b0, dead_band});
        c  = (lo + hi) >>> 1;
        fixed = 1'b1;
        upper = 1'b0;
        p_fix = 18'sd500;
        x = '0; ilo = '0; ihi = '0;
        if (w > c + s)
        begin
            upper = 1'b1;
            if (w >= hi - s)
                p_fix = 18'sd1000;
            else
            begin
                fixed = 1'b0; x = w; ilo = c + s; ihi = hi;
            end
        end
        else if (w <= c - s)
        begin
            if (w < lo + s)
                p_fix = 18'sd0;
            else
            begin
                fixed = 1'b0; x = w; ilo = lo; ihi = c - s;
            end
        end
        if (!fixed && ihi == ilo)
        begin
            fixed = 1'b1;
            p_fix = upper ? 18'sd501 : 18'sd1;
        end
    end

    assign rtry  = {rem_reg, num_reg[20]} - {8'd0, den_reg};
    assign pfull = $signed({3'b0, quo_reg}) + $signed({14'b0, base_reg});

    always_comb
    begin
        if (use_fix_reg)
            pos = pfix_reg;
        else if (pfull > 24'sd1000)
            pos = 11'd1000;
        else
            pos = pfull[10:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                lo_reg[i]   <= CAL_LOW_RESET;
                hi_reg[i]   <= CAL_HIGH_RESET;
                last_reg[i] <= NO_POSITION;
            end
            ov_reg <= 1'b0;
        end
        else
        begin
            if (pop && ov_reg)
                ov_reg <= 1'b0;
            if (ld_low)
                for (int i = 0; i < NUM_CHANNELS; i++) lo_reg[i] <= cfg_val;
            if (ld_high)
                for (int i = 0; i < NUM_CHANNELS; i++) hi_reg[i] <= cfg_val;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (m_valid && m_ready)
                    begin
                        m_reg <= m_item;
                        if (m_item.lch <= 3'd5)
                            state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    lo_reg[ch_i] <= nlo;
                    hi_reg[ch_i] <= nhi;
                    use_fix_reg  <= fixed;
                    // fixed results are in 0..1000 already
                    pfix_reg <= p_fix[10:0];
                    // x >= ilo and ihi > ilo on the linear path; both maps span 498
                    num_reg  <= 21'(x - ilo) * 21'd498;
                    den_reg  <= 14'(ihi - ilo);
                    base_reg <= upper ? 10'd501 : 10'd1;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= '0;
                    state_reg <= fixed ? S_DONE : S_DIV;
                end
                S_DIV:
                begin
                    num_reg <= {num_reg[19:0], 1'b0};
                    if (!rtry[21])
                    begin
                        rem_reg <= rtry[20:0];
                        quo_reg <= {quo_reg[19:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[19:0], num_reg[20]};
                        quo_reg <= {quo_reg[19:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd20)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (pos != last_reg[ch_i])
                    begin
                        last_reg[ch_i]        <= pos;
                        ov_reg                <= 1'b1;
                        o_reg.logical_channel <= m_reg.lch;
                        o_reg.position        <= pos[9:0];
                        o_reg.raw_width       <= m_reg.width;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hw/rtl/rc_pulse_capture_normalizer.sv @@
// rc_pulse_capture_normalizer: top level, config registers, front/queue/back.
// Depends on rcpn_pkg, rcpn_front, rcpn_fifo, rcpn_back.
// The front takes an edge whenever it is not full. For a measured width the back steps
// through take, learn, a 21-step restoring divider and compare when its position is
// linear-mapped, skips the divider on a fixed position and only takes an unmapped
// channel; it takes no new width until done with the last. Widths queue four deep
// between the two; a waiting result holds the back until it is popped.
module rc_pulse_capture_normalizer #(
    parameter int NUM_CHANNELS = 6,
    parameter int SYNC_GAP_US  = 4000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  rcpn_pkg::in_item_t   in_item,
    output logic                 empty,
    input  logic                 pop,
    output rcpn_pkg::out_item_t  out_item,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [17:0]          cfg_data
);
    import rcpn_pkg::*;

    logic        ppm_reg;
    logic [8:0]  db_reg;
    logic [17:0] map_reg;
    logic        fv, fr, qv, qr;
    meas_t       fm, qm;
    logic        ld_low, ld_high;

    assign ld_low  = cfg_we && cfg_index == REG_CAL_LOW;
    assign ld_high = cfg_we && cfg_index == REG_CAL_HIGH;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppm_reg <= 1'b0;
            db_reg  <= '0;
            map_reg <= MAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PPM_MODE:    ppm_reg <= cfg_data[0];
                REG_DEAD_BAND:   db_reg  <= cfg_data[8:0];
                REG_CHANNEL_MAP: map_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rcpn_front #(.NUM_CHANNELS(NUM_CHANNELS), .SYNC_GAP_US(SYNC_GAP_US)) u_front (
        .clk, .rst_n, .push, .full, .in_item,
        .ppm_mode(ppm_reg), .channel_map(map_reg),
        .m_valid(fv), .m_ready(fr), .m_item(fm)
    );

    rcpn_fifo u_fifo (
        .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_item(fm),
        .rd_valid(qv), .rd_ready(qr), .rd_item(qm)
    );

    rcpn_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .clk, .rst_n, .m_valid(qv), .m_ready(qr), .m_item(qm),
        .dead_band(db_reg), .ld_low, .ld_high, .cfg_val(cfg_data[11:0]),
        .empty, .pop, .out_item
    );
endmodule
